/* design/cnic_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnic_pkg
// Shared types, widths and helpers for the neighbor intersection counter.
// ----------------------------------------------------------------------------
package cnic_pkg;

    localparam int MAX_NODES    = 1024;
    localparam int MAX_NONZEROS = 8192;

    localparam int NODE_W   = 10;                       // row / column index
    localparam int LIMIT_W  = $clog2(MAX_NODES + 1);    // node count, limit
    localparam int POS_W    = 13;                       // position field
    localparam int VAL_W    = 14;                       // value field, row start
    localparam int CNT_W    = 11;                       // common count
    localparam int TYPE_W   = 2;
    localparam int RS_AW    = $clog2(MAX_NODES + 1);    // row-start table address
    localparam int COL_AW   = $clog2(MAX_NONZEROS);     // column table address
    localparam int LEN_W    = VAL_W;                    // list length / cursor

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0]   COUNT_MAX     = {CNT_W{1'b1}};
    localparam logic [LIMIT_W-1:0] NODE_LIMIT    = LIMIT_W'(MAX_NODES);
    localparam logic [VAL_W-1:0]   NNZ_LIMIT     = VAL_W'(MAX_NONZEROS);
    localparam logic [POS_W-1:0]   RS_POS_MAX    = POS_W'(MAX_NODES);
    localparam logic [LIMIT_W-1:0] NODE_COUNT_RST = LIMIT_W'(1024);

    // request type codes on the input port
    localparam logic [TYPE_W-1:0] REQ_LOAD_RS  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_LOAD_COL = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_COMPUTE  = 2'd2;

    // register index of node_count, taken from the word address
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        OP_LOAD_RS,
        OP_LOAD_COL,
        OP_COMPUTE
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [POS_W-1:0]  position;
        logic [VAL_W-1:0]  value;
        logic [NODE_W-1:0] row;
    } cmd_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_COL,
        B_RS0,
        B_RS1,
        B_RS2,
        B_RS3,
        B_RS4,
        B_LEN,
        B_SEL,
        B_XRD,
        B_XWT,
        B_YRD,
        B_YCMP,
        B_DONE
    } back_state_t;

    // Length of a neighbor list from its row-start bounds; end clipped.
    function automatic logic [LEN_W-1:0] list_len(input logic [VAL_W-1:0] s,
                                                  input logic [VAL_W-1:0] e);
        logic [VAL_W-1:0] e_clip;
        e_clip = (e > NNZ_LIMIT) ? NNZ_LIMIT : e;
        return (s < e_clip) ? LEN_W'(e_clip - s) : '0;
    endfunction

endpackage

/* design/cnic_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnic_front
// Accepts commands, drops the ones that do nothing and queues the rest.
// ----------------------------------------------------------------------------
module cnic_front
    import cnic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TYPE_W-1:0] req_type,
    input  logic [POS_W-1:0]  position,
    input  logic [VAL_W-1:0]  value,
    input  logic [NODE_W-1:0] row,
    input  logic              pop,
    output logic              busy,
    output logic              q_valid,
    output cmd_t              q_head
);

    cmd_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              accept;
    logic              keep;
    logic              push;
    logic              do_pop;
    cmd_t              cmd;

    assign busy    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_head  = q_mem[rd_ptr_reg];
    assign accept  = start && !busy;

    // classify: unused type and out-of-range row-start loads are dropped
    always_comb
    begin
        cmd.position = position;
        cmd.value    = value;
        cmd.row      = row;
        cmd.op       = OP_COMPUTE;
        keep         = 1'b0;
        case (req_type)
            REQ_LOAD_RS:
            begin
                cmd.op = OP_LOAD_RS;
                keep   = (position <= RS_POS_MAX);
            end
            REQ_LOAD_COL:
            begin
                cmd.op = OP_LOAD_COL;
                keep   = 1'b1;
            end
            REQ_COMPUTE:
            begin
                cmd.op = OP_COMPUTE;
                keep   = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push   = accept && keep;
    assign do_pop = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |=> (count_reg == $past(count_reg) - 1'b1) ||
                   (count_reg == $past(count_reg)))
        else $error("queue count wrong after pop");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count wrong after push");
`endif

endmodule

/* design/cnic_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnic_back
// Executes queued commands: table loads and the neighbor list merge.
// ----------------------------------------------------------------------------
module cnic_back
    import cnic_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cmd_t               q_head,
    input  logic [LIMIT_W-1:0] limit,
    output logic               pop,
    output logic               result_valid,
    output logic [CNT_W-1:0]   common_count,
    output logic [NODE_W-1:0]  column,
    output logic               status
);

    logic [VAL_W-1:0]  rs_mem  [MAX_NODES + 1];
    logic [NODE_W-1:0] col_mem [MAX_NONZEROS];

    back_state_t state_reg, state_next;

    logic              rs_we, col_we;
    logic [RS_AW-1:0]  rs_raddr;
    logic [COL_AW-1:0] col_raddr;
    logic [VAL_W-1:0]  rs_rdata_reg;
    logic [NODE_W-1:0] col_rdata_reg;

    logic [NODE_W-1:0] row_reg;
    logic [NODE_W-1:0] col_reg;
    logic              status_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [VAL_W-1:0]  s1_reg, e1_reg, s2_reg, e2_reg;
    logic [LEN_W-1:0]  len1_reg, len2_reg;
    logic [VAL_W-1:0]  ofirst_reg, ifirst_reg;
    logic [LEN_W-1:0]  olen_reg, ilen_reg;
    logic [LEN_W-1:0]  a_reg, b_reg, cursor_reg;
    logic [NODE_W-1:0] x_reg;
    logic              bad;
    logic [VAL_W-1:0]  x_addr, y_addr;

    assign bad = ({1'b0, row_reg} >= limit) || ({1'b0, col_rdata_reg} >= limit);
    assign x_addr = ofirst_reg + a_reg;
    assign y_addr = ifirst_reg + b_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid && q_head.op == OP_COMPUTE)
                begin
                    state_next = B_COL;
                end
            end
            B_COL:  state_next = bad ? B_DONE : B_RS0;
            B_RS0:  state_next = B_RS1;
            B_RS1:  state_next = B_RS2;
            B_RS2:  state_next = B_RS3;
            B_RS3:  state_next = B_RS4;
            B_RS4:  state_next = B_LEN;
            B_LEN:  state_next = B_SEL;
            B_SEL:  state_next = B_XRD;
            B_XRD:  state_next = (a_reg == olen_reg) ? B_DONE : B_XWT;
            B_XWT:  state_next = B_YRD;
            B_YRD:  state_next = (b_reg == ilen_reg) ? B_XRD : B_YCMP;
            B_YCMP:
            begin
                if (col_rdata_reg >= x_reg)
                begin
                    state_next = B_XRD;
                end
                else
                begin
                    state_next = B_YRD;
                end
            end
            B_DONE: state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop       = 1'b0;
        rs_we     = 1'b0;
        col_we    = 1'b0;
        rs_raddr  = RS_AW'(row_reg);
        col_raddr = q_head.position;
        case (state_reg)
            B_IDLE:
            begin
                pop    = q_valid;
                rs_we  = q_valid && (q_head.op == OP_LOAD_RS);
                col_we = q_valid && (q_head.op == OP_LOAD_COL);
            end
            B_COL:  rs_raddr  = RS_AW'(row_reg);
            B_RS0:  rs_raddr  = RS_AW'(row_reg);
            B_RS1:  rs_raddr  = RS_AW'(row_reg) + 1'b1;
            B_RS2:  rs_raddr  = RS_AW'(col_reg);
            B_RS3:  rs_raddr  = RS_AW'(col_reg) + 1'b1;
            B_XRD:  col_raddr = x_addr[COL_AW-1:0];
            B_YRD:  col_raddr = y_addr[COL_AW-1:0];
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // table storage, registered reads
    always_ff @(posedge clk)
    begin
        if (rs_we)
        begin
            rs_mem[q_head.position[RS_AW-1:0]] <= q_head.value;
        end
        rs_rdata_reg <= rs_mem[rs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[q_head.position] <= q_head.value[NODE_W-1:0];
        end
        col_rdata_reg <= col_mem[col_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                row_reg    <= q_head.row;
                count_reg  <= '0;
                status_reg <= 1'b0;
            end
            B_COL:
            begin
                col_reg    <= col_rdata_reg;
                status_reg <= bad;
            end
            B_RS1:  s1_reg <= rs_rdata_reg;
            B_RS2:  e1_reg <= rs_rdata_reg;
            B_RS3:  s2_reg <= rs_rdata_reg;
            B_RS4:  e2_reg <= rs_rdata_reg;
            B_LEN:
            begin
                len1_reg <= list_len(s1_reg, e1_reg);
                len2_reg <= list_len(s2_reg, e2_reg);
            end
            B_SEL:
            begin
                // shorter list is outer; row list wins a tie
                if (len1_reg <= len2_reg)
                begin
                    ofirst_reg <= s1_reg;
                    olen_reg   <= len1_reg;
                    ifirst_reg <= s2_reg;
                    ilen_reg   <= len2_reg;
                end
                else
                begin
                    ofirst_reg <= s2_reg;
                    olen_reg   <= len2_reg;
                    ifirst_reg <= s1_reg;
                    ilen_reg   <= len1_reg;
                end
                a_reg      <= '0;
                cursor_reg <= '0;
            end
            B_XWT:
            begin
                x_reg <= col_rdata_reg;
                b_reg <= cursor_reg;
            end
            B_YRD:
            begin
                // inner list ran out: keep cursor, advance outer
                if (b_reg == ilen_reg)
                begin
                    a_reg <= a_reg + 1'b1;
                end
            end
            B_YCMP:
            begin
                if (col_rdata_reg == x_reg)
                begin
                    if (count_reg != COUNT_MAX)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    cursor_reg <= b_reg + 1'b1;
                    a_reg      <= a_reg + 1'b1;
                end
                else if (col_rdata_reg > x_reg)
                begin
                    cursor_reg <= b_reg;
                    a_reg      <= a_reg + 1'b1;
                end
                else
                begin
                    b_reg <= b_reg + 1'b1;
                end
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign result_valid = (state_reg == B_DONE);
    assign common_count = count_reg;
    assign column       = col_reg;
    assign status       = status_reg;

`ifndef ASSERT_OFF
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status) |-> (common_count == '0))
        else $error("error result with nonzero count");

    a_inner_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_YRD) |-> (b_reg <= ilen_reg))
        else $error("inner cursor past list end");

    a_outer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_XRD) |-> (a_reg <= olen_reg))
        else $error("outer index past list end");
`endif

endmodule

/* design/csr_neighbor_intersection_count_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_neighbor_intersection_count_top
// Counts shared neighbors of two rows of a compressed-row sparse matrix.
// ----------------------------------------------------------------------------
// Commands enter through start/busy into a two-entry queue and run one at a
// time. A load is written to its table when it reaches the head of the queue
// while the back end is idle. A compute reads the column entry, checks row
// and column against the clipped node_count (out of range goes straight to
// the result), reads the row-start bounds of both rows, takes the list
// lengths and merges them, reading the shorter and the longer list in turn
// through the single read port of the column table. Each result is shown for
// exactly one cycle on result_valid and the receiver must take it then. busy
// rises only when the queue is full. node_count is written through the APB
// port at byte address 0 and should change only while no command is outstanding.
module csr_neighbor_intersection_count_top
    import cnic_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [TYPE_W-1:0]  req_type,
    input  logic [POS_W-1:0]   position,
    input  logic [VAL_W-1:0]   value,
    input  logic [NODE_W-1:0]  row,
    output logic               result_valid,
    output logic [CNT_W-1:0]   common_count,
    output logic [NODE_W-1:0]  column,
    output logic               status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [LIMIT_W-1:0] node_count_reg, node_count_next;
    logic [LIMIT_W-1:0] limit;
    logic               q_valid;
    logic               pop;
    cmd_t               q_head;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_NODE_COUNT);

    always_comb
    begin
        node_count_next = cfg_wr ? pwdata[LIMIT_W-1:0] : node_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
        end
        else
        begin
            node_count_reg <= node_count_next;
        end
    end

    assign prdata = (paddr[2] == REG_NODE_COUNT) ? {{(32 - LIMIT_W){1'b0}}, node_count_reg}
                                                 : 32'd0;

    assign limit = (node_count_reg > NODE_LIMIT) ? NODE_LIMIT : node_count_reg;

    cnic_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .position (position),
        .value    (value),
        .row      (row),
        .pop      (pop),
        .busy     (busy),
        .q_valid  (q_valid),
        .q_head   (q_head)
    );

    cnic_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .limit        (limit),
        .pop          (pop),
        .result_valid (result_valid),
        .common_count (common_count),
        .column       (column),
        .status       (status)
    );

endmodule
